// File: rtl/iirdf1_pkg.sv
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Shared types and codes for the direct form I IIR filter: field types,
// action codes, configuration register indexes and digit-serial sizing.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

  // field widths
  localparam int SAMPLE_W  = 16;
  localparam int TAPCNT_W  = 5;
  localparam int SLOT_W    = 4;
  localparam int CFG_IDX_W = 1;

  // digit-serial multiply: sample operand consumed four bits per cycle
  localparam int DIGIT_W = 4;
  localparam int DIGITS  = SAMPLE_W / DIGIT_W;

  // rounding of the Q8.29 sum down to Q1.15
  localparam int FRAC_DROP = 14;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SAMPLE_W-1:0] coef_t;
  typedef logic [1:0]                 action_t;
  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic [TAPCNT_W-1:0]        tapcnt_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  // item actions
  localparam action_t ACT_FILTER  = 2'd0;
  localparam action_t ACT_LOAD_FF = 2'd1;
  localparam action_t ACT_LOAD_FB = 2'd2;
  localparam action_t ACT_NONE    = 2'd3;

  // configuration register indexes
  localparam cfg_idx_t CFG_FF_TAPS = 1'b0;
  localparam cfg_idx_t CFG_FB_TAPS = 1'b1;

endpackage

// File: rtl/iir_direct_form_one_filter.sv
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter
// Direct form I IIR filter, Q1.15 samples, Q2.14 coefficients, rounded and
// saturated Q1.15 output with a clip flag.
// ----------------------------------------------------------------------------
// A filter item passes through the feedforward taps, the feedback taps and a
// round-and-saturate step; the next filter item can be accepted once the
// result has moved into the output register, and the round step waits while
// that register still holds an untaken result. Load items and unused actions finish in the
// cycle they are accepted. Filter timing is set by the single shared 16 x 4 bit
// multiply-accumulate: every coefficient ring makes one full rotation per
// item as the sample is fed in four-bit digits, with taps beyond the
// configured counts masked off, followed by the round-and-saturate step.
// One item is processed at a time; a finished result sits in the
// output register so the next item can be accepted while it waits to be taken.
module iir_direct_form_one_filter #(
  parameter int MAX_FF_TAPS = 16,
  parameter int MAX_FB_TAPS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // input items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  iirdf1_pkg::action_t   action,
  input  iirdf1_pkg::slot_t     tap_index,
  input  iirdf1_pkg::coef_t     coef_value,
  input  iirdf1_pkg::sample_t   sample_in,
  // result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output iirdf1_pkg::sample_t   sample_out,
  output logic                  saturated,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  iirdf1_pkg::cfg_idx_t  cfg_index,
  input  iirdf1_pkg::tapcnt_t   cfg_data
);
  import iirdf1_pkg::*;

  localparam int MAXN   = (MAX_FF_TAPS > MAX_FB_TAPS) ? MAX_FF_TAPS : MAX_FB_TAPS;
  localparam int JW     = (MAXN > 1) ? $clog2(MAXN) : 1;
  localparam int CW     = (JW > TAPCNT_W) ? JW : TAPCNT_W;
  localparam int ACC_W  = 2 * SAMPLE_W + $clog2(MAX_FF_TAPS + MAX_FB_TAPS);
  localparam int Y_W    = ACC_W - FRAC_DROP;
  localparam int PROD_W = SAMPLE_W + DIGIT_W + 1;
  localparam int KW     = $clog2(DIGITS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FF    = 2'd1;
  localparam logic [1:0] ST_FB    = 2'd2;
  localparam logic [1:0] ST_ROUND = 2'd3;

  logic [1:0]              state;
  logic [JW-1:0]           tap;
  logic [KW-1:0]           dig;
  sample_t                 opnd;
  logic signed [ACC_W-1:0] acc;
  tapcnt_t                 ff_taps_used;
  tapcnt_t                 fb_taps_used;

  coef_t   forward_coefs  [MAX_FF_TAPS];
  coef_t   feedback_coefs [MAX_FB_TAPS];
  sample_t input_history  [MAX_FF_TAPS];
  sample_t output_history [MAX_FB_TAPS];

  logic                    in_fire;
  logic                    filter_go;
  logic                    load_ff;
  logic                    load_fb;
  logic                    in_ff;
  logic                    step_last;
  logic                    tap_last;
  logic                    ff_rot;
  logic                    fb_rot;
  logic                    tap_used;
  logic                    out_free;
  logic                    finish;
  sample_t                 head;
  coef_t                   coef_head;
  sample_t                 digit_src;
  logic [DIGIT_W-1:0]      digit_raw;
  logic signed [DIGIT_W:0] digit_s;
  logic signed [PROD_W-1:0] prod;
  logic [4:0]              shamt;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] rsum;
  logic signed [Y_W-1:0]   yw;
  logic                    pos_sat;
  logic                    neg_sat;
  sample_t                 y_val;

  // handshakes
  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign filter_go = in_fire && (action == ACT_FILTER);
  assign load_ff   = in_fire && (action == ACT_LOAD_FF);
  assign load_fb   = in_fire && (action == ACT_LOAD_FB);
  assign out_free  = !out_valid || out_ready;
  assign finish    = (state == ST_ROUND) && out_free;

  // tap sequencing
  assign in_ff     = (state == ST_FF);
  assign step_last = (dig == KW'(DIGITS - 1));
  assign tap_last  = in_ff ? (tap == JW'(MAX_FF_TAPS - 1)) : (tap == JW'(MAX_FB_TAPS - 1));
  assign ff_rot    = in_ff && step_last;
  assign fb_rot    = (state == ST_FB) && step_last;
  assign tap_used  = in_ff ? (CW'(tap) < CW'(ff_taps_used)) : (CW'(tap) < CW'(fb_taps_used));

  // digit-serial product of the head coefficient and one sample digit
  assign head      = in_ff ? input_history[0] : output_history[0];
  assign coef_head = in_ff ? forward_coefs[0] : feedback_coefs[0];
  assign digit_src = (dig == '0) ? head : opnd;
  assign digit_raw = digit_src[DIGIT_W-1:0];
  assign digit_s   = step_last ? {digit_raw[DIGIT_W-1], digit_raw} : {1'b0, digit_raw};
  assign prod      = coef_head * digit_s;
  assign shamt     = 5'(dig) * 5'(DIGIT_W);
  assign term      = ACC_W'(prod) <<< shamt;

  // rounding and saturation of the finished sum
  assign rsum    = acc + ACC_W'(signed'(1 <<< (FRAC_DROP - 1)));
  assign yw      = Y_W'(rsum >>> FRAC_DROP);
  assign pos_sat = !yw[Y_W-1] && (|yw[Y_W-1:SAMPLE_W-1]);
  assign neg_sat = yw[Y_W-1] && !(&yw[Y_W-1:SAMPLE_W-1]);
  always_comb begin
    priority if (pos_sat) begin
      y_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (neg_sat) begin
      y_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_val = yw[SAMPLE_W-1:0];
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tap   <= '0;
      dig   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (filter_go) begin
            state <= ST_FF;
            tap   <= '0;
            dig   <= '0;
          end
        end
        ST_FF, ST_FB: begin
          dig <= dig + 1'b1;
          if (step_last) begin
            if (tap_last) begin
              tap   <= '0;
              state <= in_ff ? ST_FB : ST_ROUND;
            end else begin
              tap <= tap + 1'b1;
            end
          end
        end
        ST_ROUND: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // operand shift register and accumulator
  always_ff @(posedge clk) begin
    if (filter_go) begin
      acc <= '0;
    end else if ((state == ST_FF) || (state == ST_FB)) begin
      opnd <= digit_src >> DIGIT_W;
      if (tap_used) begin
        acc <= in_ff ? (acc + term) : (acc - term);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ff_taps_used <= TAPCNT_W'(1);
      fb_taps_used <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FF_TAPS: ff_taps_used <= cfg_data;
        CFG_FB_TAPS: fb_taps_used <= cfg_data;
        default: ;
      endcase
    end
  end

  // feedforward coefficient ring: slot load, rotate once per tap
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_FF_TAPS; i++) forward_coefs[i] <= '0;
    end else if (load_ff) begin
      for (int i = 0; i < MAX_FF_TAPS; i++) begin
        if (32'(tap_index) == i) forward_coefs[i] <= coef_value;
      end
    end else if (ff_rot) begin
      for (int i = 0; i < MAX_FF_TAPS - 1; i++) forward_coefs[i] <= forward_coefs[i+1];
      forward_coefs[MAX_FF_TAPS-1] <= forward_coefs[0];
    end
  end

  // feedback coefficient ring
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_FB_TAPS; i++) feedback_coefs[i] <= '0;
    end else if (load_fb) begin
      for (int i = 0; i < MAX_FB_TAPS; i++) begin
        if (32'(tap_index) == i) feedback_coefs[i] <= coef_value;
      end
    end else if (fb_rot) begin
      for (int i = 0; i < MAX_FB_TAPS - 1; i++) feedback_coefs[i] <= feedback_coefs[i+1];
      feedback_coefs[MAX_FB_TAPS-1] <= feedback_coefs[0];
    end
  end

  // input history: new sample shifts in, then rotates with the coefficients
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_FF_TAPS; i++) input_history[i] <= '0;
    end else if (filter_go) begin
      for (int i = 1; i < MAX_FF_TAPS; i++) input_history[i] <= input_history[i-1];
      input_history[0] <= sample_in;
    end else if (ff_rot) begin
      for (int i = 0; i < MAX_FF_TAPS - 1; i++) input_history[i] <= input_history[i+1];
      input_history[MAX_FF_TAPS-1] <= input_history[0];
    end
  end

  // output history: rotates during feedback taps, saturated result shifts in
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_FB_TAPS; i++) output_history[i] <= '0;
    end else if (finish) begin
      for (int i = 1; i < MAX_FB_TAPS; i++) output_history[i] <= output_history[i-1];
      output_history[0] <= y_val;
    end else if (fb_rot) begin
      for (int i = 0; i < MAX_FB_TAPS - 1; i++) output_history[i] <= output_history[i+1];
      output_history[MAX_FB_TAPS-1] <= output_history[0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      sample_out <= y_val;
      saturated  <= pos_sat || neg_sat;
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the direct form I IIR filter. Coefficient loads,
// unused actions and filter samples go in over the input handshake. A
// bit-exact filter model predicts every output sample and its clip flag.
// Runs a short directed set and then random phases under several tap
// settings, with random stalls on both sides and one long output hold.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import iirdf1_pkg::*;

  localparam int FF_DEPTH      = 16;
  localparam int FB_DEPTH      = 16;
  localparam int LATENCY       = 4 * (FF_DEPTH + FB_DEPTH) + 2;
  localparam int SETTLE_CYCLES = LATENCY + 10;
  localparam int HOLD_AFTER    = 100;
  localparam int HOLD_CYCLES   = 1200;
  localparam int WATCHDOG_MAX  = 10000;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 200;

  localparam sample_t SAMPLE_MAX = 16'sh7fff;
  localparam sample_t SAMPLE_MIN = 16'sh8000;

  // tap settings per random phase, extremes and out-of-range counts included
  localparam tapcnt_t FF_PLAN [PHASES] = '{5'd16, 5'd0, 5'd31, 5'd4, 5'd1, 5'd17, 5'd8};
  localparam tapcnt_t FB_PLAN [PHASES] = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd16, 5'd2, 5'd8};

  typedef struct packed {
    sample_t y;
    logic    sat;
  } filter_out_t;

  typedef struct packed {
    action_t act;
    slot_t   slot;
    coef_t   coef;
    sample_t x;
  } df1_item_t;

  // filter model and queue of predicted outputs
  class df1_scoreboard;
    coef_t       ff_coef [FF_DEPTH];
    coef_t       fb_coef [FB_DEPTH];
    sample_t     x_hist [FF_DEPTH];
    sample_t     y_hist [FB_DEPTH];
    tapcnt_t     ff_count;
    tapcnt_t     fb_count;
    filter_out_t expected_outputs [$];
    int          mismatches;
    int          results_checked;
    int          clipped;

    function new();
      foreach (ff_coef[j]) begin
        ff_coef[j] = '0;
        x_hist[j]  = '0;
      end
      foreach (fb_coef[j]) begin
        fb_coef[j] = '0;
        y_hist[j]  = '0;
      end
      ff_count        = 5'd1;
      fb_count        = 5'd0;
      mismatches      = 0;
      results_checked = 0;
      clipped         = 0;
    endfunction

    function void set_tap_count(cfg_idx_t idx, tapcnt_t count);
      if (idx == CFG_FF_TAPS) begin
        ff_count = count;
      end else begin
        fb_count = count;
      end
    endfunction

    // apply one accepted item, predicting the output of a filter action
    function void accept_item(df1_item_t it);
      int unsigned nff;
      int unsigned nfb;
      longint      acc;
      longint      rounded;
      filter_out_t res;
      case (it.act)
        ACT_LOAD_FF: begin
          ff_coef[it.slot] = it.coef;
        end
        ACT_LOAD_FB: begin
          fb_coef[it.slot] = it.coef;
        end
        ACT_FILTER: begin
          nff = (ff_count > FF_DEPTH) ? FF_DEPTH : ff_count;
          nfb = (fb_count > FB_DEPTH) ? FB_DEPTH : fb_count;
          for (int j = FF_DEPTH - 1; j > 0; j--) x_hist[j] = x_hist[j-1];
          x_hist[0] = it.x;
          acc = 0;
          for (int j = 0; j < nff; j++) acc += longint'(ff_coef[j]) * longint'(x_hist[j]);
          for (int j = 0; j < nfb; j++) acc -= longint'(fb_coef[j]) * longint'(y_hist[j]);
          // half-up rounding from Q8.29 to Q1.15, then clip
          rounded = (acc + 64'sd8192) >>> FRAC_DROP;
          if (rounded > 32767) begin
            res.y   = SAMPLE_MAX;
            res.sat = 1'b1;
          end else if (rounded < -32768) begin
            res.y   = SAMPLE_MIN;
            res.sat = 1'b1;
          end else begin
            res.y   = rounded[15:0];
            res.sat = 1'b0;
          end
          for (int j = FB_DEPTH - 1; j > 0; j--) y_hist[j] = y_hist[j-1];
          y_hist[0] = res.y;
          expected_outputs.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_output(sample_t got_y, logic got_sat);
      filter_out_t want;
      if (expected_outputs.size() == 0) begin
        $error("unexpected filter output %0d with nothing pending", $signed(got_y));
        mismatches++;
        return;
      end
      want = expected_outputs.pop_front();
      results_checked++;
      if (want.sat) clipped++;
      if (got_y !== want.y) begin
        $error("sample_out mismatch: expected %0d, actual %0d",
               $signed(want.y), $signed(got_y));
        mismatches++;
      end
      if (got_sat !== want.sat) begin
        $error("saturated mismatch: expected %0b, actual %0b", want.sat, got_sat);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction
  endclass

  logic     clk        = 1'b0;
  logic     rst        = 1'b1;
  logic     in_valid   = 1'b0;
  logic     in_ready;
  action_t  action     = ACT_FILTER;
  slot_t    tap_index  = '0;
  coef_t    coef_value = '0;
  sample_t  sample_in  = '0;
  logic     out_valid;
  logic     out_ready  = 1'b0;
  sample_t  sample_out;
  logic     saturated;
  logic     cfg_valid  = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index  = CFG_FF_TAPS;
  tapcnt_t  cfg_data   = '0;

  df1_scoreboard sb;
  logic          no_idle    = 1'b0;
  logic          hold_done  = 1'b0;
  int            items_sent = 0;
  int            ignored    = 0;
  int            cfg_writes = 0;
  int            idle_count = 0;

  iir_direct_form_one_filter #(
    .MAX_FF_TAPS(FF_DEPTH),
    .MAX_FB_TAPS(FB_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .tap_index (tap_index),
    .coef_value(coef_value),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample_out(sample_out),
    .saturated (saturated),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic df1_item_t make_item(action_t act, slot_t slot, coef_t coef, sample_t x);
    df1_item_t it;
    it.act  = act;
    it.slot = slot;
    it.coef = coef;
    it.x    = x;
    return it;
  endfunction

  // random item: mostly filter samples, frequent coefficient reloads
  function automatic df1_item_t random_item();
    df1_item_t   it;
    int unsigned pick;
    pick    = $urandom_range(0, 99);
    it.act  = (pick < 60) ? ACT_FILTER : (pick < 77) ? ACT_LOAD_FF :
              (pick < 94) ? ACT_LOAD_FB : ACT_NONE;
    it.slot = slot_t'($urandom_range(0, 15));
    // small coefficients keep the loop mostly in range
    if ($urandom_range(0, 3) == 0) it.coef = coef_t'($urandom);
    else it.coef = coef_t'(int'($urandom_range(0, 1022)) - 511);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 4))
        0: it.x = SAMPLE_MAX;
        1: it.x = SAMPLE_MIN;
        2: it.x = 16'sd1;
        3: it.x = -16'sd1;
        default: it.x = '0;
      endcase
    end else begin
      it.x = sample_t'($urandom);
    end
    return it;
  endfunction

  task automatic write_register(cfg_idx_t idx, tapcnt_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_tap_count(idx, val);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // present one item and hold it until taken; valid stays high on return
  task automatic send_item(df1_item_t it);
    @(negedge clk);
    in_valid   <= 1'b1;
    action     <= it.act;
    tap_index  <= it.slot;
    coef_value <= it.coef;
    sample_in  <= it.x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.accept_item(it);
    if (it.act == ACT_NONE) ignored++;
    else items_sent++;
  endtask

  task automatic pause_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // wait for every predicted output, then let the datapath go quiet
  task automatic drain_and_settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_with_gap(df1_item_t it);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) pause_input(gap);
    send_item(it);
  endtask

  // output side: random stalls, one long hold once traffic is flowing
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!rst && !hold_done && sb.results_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if (no_idle || stall_left == 0) begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 9) == 0) stall_left = pick_gap();
      end else begin
        out_ready <= 1'b0;
        stall_left--;
      end
    end
  end

  // compare each taken output with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_output(sample_out, saturated);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // stimulus
  initial begin
    df1_item_t directed [$];
    int        counted;
    df1_item_t it;
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed part under the reset tap counts (one forward tap, no feedback)
    directed.push_back(make_item(ACT_FILTER, 4'd0, 16'sd0, SAMPLE_MAX));
    directed.push_back(make_item(ACT_LOAD_FF, 4'd0, 16'sd16384, 16'sd0));
    directed.push_back(make_item(ACT_FILTER, 4'd0, 16'sd0, SAMPLE_MAX));
    directed.push_back(make_item(ACT_FILTER, 4'd0, 16'sd0, SAMPLE_MIN));
    // most negative coefficient drives both clip directions
    directed.push_back(make_item(ACT_LOAD_FF, 4'd0, 16'sh8000, 16'sd0));
    directed.push_back(make_item(ACT_FILTER, 4'd0, 16'sd0, SAMPLE_MIN));
    directed.push_back(make_item(ACT_FILTER, 4'd0, 16'sd0, SAMPLE_MAX));
    // tiny coefficient probes the half-up rounding boundary
    directed.push_back(make_item(ACT_LOAD_FF, 4'd0, 16'sd1, 16'sd0));
    directed.push_back(make_item(ACT_FILTER, 4'd0, 16'sd0, 16'sd8192));
    directed.push_back(make_item(ACT_FILTER, 4'd0, 16'sd0, -16'sd8192));
    directed.push_back(make_item(ACT_FILTER, 4'd0, 16'sd0, 16'sd8191));
    directed.push_back(make_item(ACT_FILTER, 4'd0, 16'sd0, -16'sd8193));
    // top slots of both banks and feedback slot 0, then an unused action with every bit set
    directed.push_back(make_item(ACT_LOAD_FF, 4'd15, SAMPLE_MAX, 16'sd0));
    directed.push_back(make_item(ACT_LOAD_FB, 4'd15, SAMPLE_MIN, 16'sd0));
    directed.push_back(make_item(ACT_LOAD_FB, 4'd0, SAMPLE_MAX, 16'sd0));
    directed.push_back(make_item(ACT_NONE, 4'd15, -16'sd1, -16'sd1));
    directed.push_back(make_item(ACT_FILTER, 4'd0, 16'sd0, 16'sd0));
    directed.push_back(make_item(ACT_LOAD_FF, 4'd0, SAMPLE_MAX, 16'sd0));
    directed.push_back(make_item(ACT_FILTER, 4'd0, 16'sd0, SAMPLE_MAX));
    directed.push_back(make_item(ACT_FILTER, 4'd0, 16'sd0, -16'sd1));
    foreach (directed[k]) send_with_gap(directed[k]);
    pause_input(1);

    // random phases, each under its own tap counts
    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      write_register(CFG_FF_TAPS, FF_PLAN[p]);
      write_register(CFG_FB_TAPS, FB_PLAN[p]);
      no_idle = (p == 3 || p == 6);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        it = random_item();
        send_with_gap(it);
        if (it.act != ACT_NONE) counted++;
      end
      pause_input(1);
    end
    no_idle = 1'b0;

    drain_and_settle();
    $display("sent %0d items plus %0d unused actions; %0d outputs checked, %0d clipped",
             items_sent, ignored, sb.results_checked, sb.clipped);
    $display("%0d tap count writes over %0d settings, output held off %0d cycles once",
             cfg_writes, PHASES, HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: iir_direct_form_one_filter.f
rtl/iirdf1_pkg.sv
rtl/iir_direct_form_one_filter.sv
tb/sv/tb_top.sv
